// ----- hdl/ncfb_pkg.sv -----
// ----------------------------------------------------------------------------
// ncfb_pkg - shared types and constants of the nfc command frame builder
// Frame byte constants, the command handed from front to back, and the
// output sequencer steps.
// ----------------------------------------------------------------------------
package ncfb_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0] START_BYTE    = 8'hFF;
    localparam logic [7:0] TFI_HOST      = 8'hD4;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;
    localparam logic [7:0] MAX_PAYLOAD   = 8'd254;

    // default command queue depth
    localparam int unsigned CMD_DEPTH = 4;

    // one classified payload byte
    typedef struct packed {
        logic       wake;   // emit wakeup preamble first
        logic       hdr;    // first byte of frame, emit header first
        logic       last;   // last byte of frame, emit checksum and postamble
        logic [7:0] data;   // payload byte
        logic [7:0] lenb;   // length byte (payload + 1)
        logic [7:0] dcs;    // data checksum
    } cmd_t;

    // output sequencer steps, in stream order
    typedef enum logic [3:0] {
        ST_WAKE0, ST_WAKE1, ST_WAKE2, ST_WAKE3, ST_WAKE4,
        ST_SOF0,  ST_SOF1,  ST_START, ST_LEN,   ST_LCS,
        ST_TFI,   ST_DATA,  ST_DCS,   ST_POST
    } step_t;

endpackage

// ----- hdl/ncfb_front.sv -----
// ----------------------------------------------------------------------------
// ncfb_front - input classifier
// Tracks frame position and running sum, turns each payload byte into a
// command for the output sequencer.
// ----------------------------------------------------------------------------
module ncfb_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic [7:0]    in_len,
    output logic          push,
    input  logic          full,
    output ncfb_pkg::cmd_t cmd
);
    import ncfb_pkg::*;

    logic       send_wakeup_reg, send_wakeup_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] data_sum_reg, data_sum_next;

    logic [7:0] len_clamped;
    logic [7:0] left;
    logic [7:0] sum;

    assign cfg_ready = 1'b1;
    assign push      = in_valid && !full;

    always_comb begin
        priority if (in_len == ZERO_BYTE) begin
            len_clamped = 8'd1;
        end else if (in_len > MAX_PAYLOAD) begin
            len_clamped = MAX_PAYLOAD;
        end else begin
            len_clamped = in_len;
        end

        if (in_frame_reg) begin
            left = 8'(bytes_left_reg - 8'd1);
            sum  = 8'(data_sum_reg + in_byte);
        end else begin
            left = 8'(len_clamped - 8'd1);
            sum  = 8'(TFI_HOST + in_byte);
        end

        cmd.wake = !in_frame_reg && send_wakeup_reg;
        cmd.hdr  = !in_frame_reg;
        cmd.last = (left == 8'd0);
        cmd.data = in_byte;
        cmd.lenb = 8'(len_clamped + 8'd1);
        cmd.dcs  = 8'(ZERO_BYTE - sum);

        send_wakeup_next = (cfg_valid && cfg_ready) ? cfg_data : send_wakeup_reg;
        in_frame_next    = in_frame_reg;
        bytes_left_next  = bytes_left_reg;
        data_sum_next    = data_sum_reg;
        if (push) begin
            in_frame_next   = !cmd.last;
            bytes_left_next = left;
            data_sum_next   = cmd.last ? ZERO_BYTE : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_wakeup_reg <= 1'b1;
            in_frame_reg    <= 1'b0;
            bytes_left_reg  <= 8'd0;
            data_sum_reg    <= 8'd0;
        end else begin
            send_wakeup_reg <= send_wakeup_next;
            in_frame_reg    <= in_frame_next;
            bytes_left_reg  <= bytes_left_next;
            data_sum_reg    <= data_sum_next;
        end
    end

    // outside a frame the remaining count is always cleared
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (bytes_left_reg == 8'd0 && data_sum_reg == 8'd0))
        else $error("front: stale count or sum outside frame");

endmodule

// ----- hdl/ncfb_fifo.sv -----
// ----------------------------------------------------------------------------
// ncfb_fifo - command queue
// Small first-in first-out queue between classifier and sequencer.
// ----------------------------------------------------------------------------
module ncfb_fifo #(
    parameter int unsigned DEPTH = ncfb_pkg::CMD_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ncfb_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           pop,
    output ncfb_pkg::cmd_t rd_cmd,
    output logic           not_empty
);
    import ncfb_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cmd_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        end
        unique case ({push, pop})
            2'b10:   count_next = CntW'(count_reg + 1'b1);
            2'b01:   count_next = CntW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("fifo: push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("fifo: pop while empty");

endmodule

// ----- hdl/ncfb_back.sv -----
// ----------------------------------------------------------------------------
// ncfb_back - output sequencer
// Expands each command into its frame bytes, one byte per cycle while m_tready
// does not stall the output, into a registered output stage.
// ----------------------------------------------------------------------------
module ncfb_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  ncfb_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import ncfb_pkg::*;

    step_t      step_reg, step_next;
    logic       busy_reg, busy_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    step_t      cur_step;
    logic       load;
    logic       final_step;
    logic [7:0] byte_val;

    always_comb begin
        if (busy_reg) begin
            cur_step = step_reg;
        end else if (head.wake) begin
            cur_step = ST_WAKE0;
        end else if (head.hdr) begin
            cur_step = ST_SOF0;
        end else begin
            cur_step = ST_DATA;
        end

        load       = head_valid && (!m_tvalid_reg || m_tready);
        final_step = (cur_step == ST_POST) || (cur_step == ST_DATA && !head.last);
        pop        = load && final_step;

        unique case (cur_step)
            ST_WAKE0, ST_WAKE1: byte_val = PREAMBLE_BYTE;
            ST_START:           byte_val = START_BYTE;
            ST_LEN:             byte_val = head.lenb;
            ST_LCS:             byte_val = 8'(ZERO_BYTE - head.lenb);
            ST_TFI:             byte_val = TFI_HOST;
            ST_DATA:            byte_val = head.data;
            ST_DCS:             byte_val = head.dcs;
            default:            byte_val = ZERO_BYTE;
        endcase

        step_next     = step_reg;
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = byte_val;
            m_tlast_next  = (cur_step == ST_POST);
            busy_next     = !final_step;
            step_next     = step_t'(4'(cur_step + 4'd1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_WAKE0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // the postamble byte is the one and only frame-end beat
    a_post_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_tlast == ($past(cur_step) == ST_POST)))
        else $error("back: frame end flag does not match postamble step");

endmodule

// ----- hdl/nfc_command_frame_builder_top.sv -----
// ----------------------------------------------------------------------------
// nfc_command_frame_builder_top - host-to-controller command frame builder
// Wraps payload bytes into information frames for an nfc controller link.
// ----------------------------------------------------------------------------
// Payload bytes enter on the s_ stream, one per beat; the payload length is
// taken from the first beat of each frame only (0 counts as 1, 255 as 254).
// The m_ stream carries the framed bytes: optional wakeup preamble
// 55 55 00 00 00 (cfg_data = 1, the reset value, sampled at frame start),
// header 00 00 ff, length, length checksum, d4, the payload, data checksum
// and a 00 postamble flagged with m_tlast. A front stage classifies every
// beat and pushes one command into a queue of FIFO_DEPTH entries; a back
// sequencer expands each command into 1 to 14 output beats at one beat per
// cycle while m_tready does not stall it, through a registered output stage.
// The input takes one beat per cycle while the queue has room, so a frame of
// n payload bytes becomes n + 8 output beats (n + 13 with the preamble),
// which is what sets the sustained input rate. cfg writes are always accepted
// and should be made between frames.
// ----------------------------------------------------------------------------
module nfc_command_frame_builder_top #(
    parameter int unsigned FIFO_DEPTH = ncfb_pkg::CMD_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: send_wakeup
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // payload input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] payload_len
    // framed output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // frame_end
);
    import ncfb_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    // queue room is the only thing that stalls the input
    assign s_tready = !full;

    ncfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata[7:0]),
        .in_len    (s_tdata[15:8]),
        .push      (push),
        .full      (full),
        .cmd       (front_cmd)
    );

    ncfb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_cmd    (front_cmd),
        .full      (full),
        .pop       (pop),
        .rd_cmd    (head_cmd),
        .not_empty (head_valid)
    );

    ncfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
